FILE: hdl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types and constants for the two-prime CRT reconstruction block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

    localparam int MODULUS_BITS_DEF = 60;

    // result word layout
    localparam int LOW_W   = 64;
    localparam int HIGH_W  = 55;
    localparam int MAG_TOP = LOW_W + HIGH_W - 1;
    // centered difference wraps at this width
    localparam int WIDE_W  = 128;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int LIMBS_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOD_FIRST  = 2'd0,
        CFG_MOD_SECOND = 2'd1,
        CFG_INV        = 2'd2,
        CFG_LIMBS      = 2'd3
    } t_cfg_idx;

    localparam logic [LIMBS_W-1:0] LIMBS_ONE   = 2'd1;
    localparam logic [LIMBS_W-1:0] LIMBS_RESET = 2'd2;
    localparam int MOD_RESET = 2;
    localparam int INV_RESET = 0;

    // control bits that travel with each word through the pipeline
    typedef struct packed {
        logic valid;
        logic bad;
    } t_tag;

    // one finished result word
    typedef struct packed {
        logic              neg;
        logic [LOW_W-1:0]  mag_low;
        logic [HIGH_W-1:0] mag_high;
        logic              bad;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/rcc_mod_reduce.sv
// ----------------------------------------------------------------------------
// rcc_mod_reduce
// Pipelined restoring reduction of several lanes by one modulus, one
// dividend bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_mod_reduce import rcc_pkg::*; #(
    parameter int MB    = MODULUS_BITS_DEF,
    parameter int LANES = 3
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire  [MB-1:0]               i_mod,
    input  t_tag                        i_tag,
    input  wire  [MB-1:0]               i_r0,
    input  wire  [LANES-1:0][MB-1:0]    i_val,
    output t_tag                        o_tag,
    output logic [MB-1:0]               o_r0,
    output logic [LANES-1:0][MB-1:0]    o_rem
);

    t_tag                     stg_tag  [0:MB];
    logic [MB-1:0]            stg_r0   [0:MB];
    logic [LANES-1:0][MB-1:0] stg_rem  [0:MB];
    logic [LANES-1:0][MB-1:0] stg_bits [0:MB];

    assign stg_tag[0]  = i_tag;
    assign stg_r0[0]   = i_r0;
    assign stg_rem[0]  = '0;
    assign stg_bits[0] = i_val;

    for (genvar k = 0; k < MB; k++) begin : g_stage
        logic [LANES-1:0][MB-1:0] n_rem;
        logic [LANES-1:0][MB-1:0] n_bits;
        t_tag                     r_tag;
        logic [MB-1:0]            r_r0;
        logic [LANES-1:0][MB-1:0] r_rem;
        logic [LANES-1:0][MB-1:0] r_bits;

        always_comb begin
            logic [MB:0] t;
            logic [MB:0] diff;
            for (int l = 0; l < LANES; l++) begin
                t    = {stg_rem[k][l], stg_bits[k][l][MB-1]};
                diff = t - (MB+1)'(i_mod);
                n_rem[l]  = (t >= (MB+1)'(i_mod)) ? diff[MB-1:0] : t[MB-1:0];
                n_bits[l] = {stg_bits[k][l][MB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag <= '0;
            end else if (i_en) begin
                r_tag <= stg_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r0   <= stg_r0[k];
                r_rem  <= n_rem;
                r_bits <= n_bits;
            end
        end

        assign stg_tag[k+1]  = r_tag;
        assign stg_r0[k+1]   = r_r0;
        assign stg_rem[k+1]  = r_rem;
        assign stg_bits[k+1] = r_bits;
    end

    assign o_tag = stg_tag[MB];
    assign o_r0  = stg_r0[MB];
    assign o_rem = stg_rem[MB];

endmodule

`default_nettype wire

FILE: hdl/rcc_mod_mul.sv
// ----------------------------------------------------------------------------
// rcc_mod_mul
// Pipelined modular multiply x*y mod m by double-and-add, one multiplier
// bit per stage. Both operands are expected below m.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_mod_mul import rcc_pkg::*; #(
    parameter int MB = MODULUS_BITS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_en,
    input  wire  [MB-1:0] i_mod,
    input  t_tag          i_tag,
    input  wire  [MB-1:0] i_r0,
    input  wire  [MB-1:0] i_x,
    input  wire  [MB-1:0] i_y,
    output t_tag          o_tag,
    output logic [MB-1:0] o_r0,
    output logic [MB-1:0] o_prod
);

    localparam int T_W = MB + 2;

    t_tag          stg_tag [0:MB];
    logic [MB-1:0] stg_r0  [0:MB];
    logic [MB-1:0] stg_acc [0:MB];
    logic [MB-1:0] stg_x   [0:MB];
    logic [MB-1:0] stg_y   [0:MB];

    logic [T_W-1:0] mod_1x;
    logic [T_W-1:0] mod_2x;

    assign mod_1x = T_W'(i_mod);
    assign mod_2x = T_W'({i_mod, 1'b0});

    assign stg_tag[0] = i_tag;
    assign stg_r0[0]  = i_r0;
    assign stg_acc[0] = '0;
    assign stg_x[0]   = i_x;
    assign stg_y[0]   = i_y;

    for (genvar k = 0; k < MB; k++) begin : g_stage
        logic [MB-1:0] n_acc;
        t_tag          r_tag;
        logic [MB-1:0] r_r0;
        logic [MB-1:0] r_acc;
        logic [MB-1:0] r_x;
        logic [MB-1:0] r_y;

        always_comb begin
            logic [T_W-1:0] t;
            logic [T_W-1:0] sub1;
            logic [T_W-1:0] sub2;
            t    = T_W'({stg_acc[k], 1'b0})
                 + (stg_y[k][MB-1] ? T_W'(stg_x[k]) : '0);
            sub1 = t - mod_1x;
            sub2 = t - mod_2x;
            // sum is below three times the modulus
            if (t >= mod_2x) begin
                n_acc = sub2[MB-1:0];
            end else if (t >= mod_1x) begin
                n_acc = sub1[MB-1:0];
            end else begin
                n_acc = t[MB-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag <= '0;
            end else if (i_en) begin
                r_tag <= stg_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r0  <= stg_r0[k];
                r_acc <= n_acc;
                r_x   <= stg_x[k];
                r_y   <= {stg_y[k][MB-2:0], 1'b0};
            end
        end

        assign stg_tag[k+1] = r_tag;
        assign stg_r0[k+1]  = r_r0;
        assign stg_acc[k+1] = r_acc;
        assign stg_x[k+1]   = r_x;
        assign stg_y[k+1]   = r_y;
    end

    assign o_tag  = stg_tag[MB];
    assign o_r0   = stg_r0[MB];
    assign o_prod = stg_acc[MB];

endmodule

`default_nettype wire

FILE: hdl/rcc_wide_mul.sv
// ----------------------------------------------------------------------------
// rcc_wide_mul
// Three-stage a*b + addend: half-width partial products, then combine,
// then final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_wide_mul import rcc_pkg::*; #(
    parameter int MB = MODULUS_BITS_DEF
) (
    input  wire             i_clk,
    input  wire             i_en,
    input  wire  [MB-1:0]   i_a,
    input  wire  [MB-1:0]   i_b,
    input  wire  [MB-1:0]   i_addend,
    output logic [2*MB:0]   o_prod
);

    localparam int LO_W = (MB + 1) / 2;
    localparam int HI_W = MB - LO_W;
    localparam int LL_W = 2 * LO_W;
    localparam int HH_W = 2 * HI_W;
    localparam int P_W  = 2 * MB + 1;

    logic [LL_W-1:0] r_pp_ll;
    logic [MB-1:0]   r_pp_lh;
    logic [MB-1:0]   r_pp_hl;
    logic [HH_W-1:0] r_pp_hh;
    logic [MB-1:0]   r_add1;

    logic [2*MB-1:0] r_outer;
    logic [MB:0]     r_mid;
    logic [MB-1:0]   r_add2;

    logic [P_W-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_ll <= LL_W'(i_a[LO_W-1:0]) * LL_W'(i_b[LO_W-1:0]);
            r_pp_lh <= MB'(i_a[LO_W-1:0]) * MB'(i_b[MB-1:LO_W]);
            r_pp_hl <= MB'(i_a[MB-1:LO_W]) * MB'(i_b[LO_W-1:0]);
            r_pp_hh <= HH_W'(i_a[MB-1:LO_W]) * HH_W'(i_b[MB-1:LO_W]);
            r_add1  <= i_addend;

            // outer products do not overlap
            r_outer <= {r_pp_hh, r_pp_ll};
            r_mid   <= (MB+1)'(r_pp_lh) + (MB+1)'(r_pp_hl);
            r_add2  <= r_add1;

            r_prod  <= P_W'(r_outer) + (P_W'(r_mid) << LO_W) + P_W'(r_add2);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: hdl/rcc_out_fifo.sv
// ----------------------------------------------------------------------------
// rcc_out_fifo
// Two-word result buffer that decouples the pipeline from the output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_out_fifo import rcc_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_push,
    input  t_result i_data,
    input  wire     i_pop,
    output t_result o_data,
    output logic    o_valid,
    output logic    o_full
);

    localparam int DEPTH = 2;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result    r_mem [0:DEPTH-1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full result buffer");

    a_cnt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && !i_pop) |=> $stable(r_cnt))
        else $error("result count moved without push or pop");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("result count beyond depth");

endmodule

`default_nettype wire

FILE: hdl/rns_crt_centered_reconstruct.sv
// ----------------------------------------------------------------------------
// rns_crt_centered_reconstruct
// Two-prime Garner CRT reconstruction of one coefficient, centered modulo
// the product of the primes, or modulo the first prime in one-limb mode.
// ----------------------------------------------------------------------------
// path: input register, the bit-per-stage reduction chain, the difference register,
//   the bit-per-stage modular multiply, the wide multiply, the sign register, then the result buffer
// throughput: one word per cycle while the two-word result buffer is not full; a full buffer stalls the input
// reset: configuration returns to p0 = 2, p1 = 2, inverse = 0, two limbs;
//   all pipeline valid bits and the result buffer are cleared
`default_nettype none

module rns_crt_centered_reconstruct import rcc_pkg::*; #(
    parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,

    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire  [MODULUS_BITS-1:0] i_residue_first,
    input  wire  [MODULUS_BITS-1:0] i_residue_second,

    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic                    o_is_negative,
    output logic [LOW_W-1:0]        o_magnitude_low,
    output logic [HIGH_W-1:0]       o_magnitude_high,
    output logic                    o_bad_residue,

    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [MODULUS_BITS-1:0] i_cfg_data
);

    localparam int MB     = MODULUS_BITS;
    localparam int P_W    = 2 * MB + 1;
    localparam int MUL_LAT = 3;

    // configuration
    logic [MB-1:0]      r_p0;
    logic [MB-1:0]      r_p1;
    logic [MB-1:0]      r_inv;
    logic [LIMBS_W-1:0] r_limbs;
    logic               one_limb;

    assign o_cfg_ready = 1'b1;
    assign one_limb    = (r_limbs == LIMBS_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0    <= MB'(MOD_RESET);
            r_p1    <= MB'(MOD_RESET);
            r_inv   <= MB'(INV_RESET);
            r_limbs <= LIMBS_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MOD_FIRST:  r_p0    <= i_cfg_data;
                CFG_MOD_SECOND: r_p1    <= i_cfg_data;
                CFG_INV:        r_inv   <= i_cfg_data;
                CFG_LIMBS:      r_limbs <= i_cfg_data[LIMBS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline advance
    logic    pipe_en;
    logic    fifo_full;
    t_result fifo_data;

    assign pipe_en    = !fifo_full;
    assign o_in_stall = fifo_full;

    // input stage
    t_tag          r_in_tag;
    logic [MB-1:0] r_in_r0;
    logic [MB-1:0] r_in_r1;
    t_tag          n_in_tag;

    always_comb begin
        n_in_tag.valid = i_in_valid;
        n_in_tag.bad   = (i_residue_first >= r_p0)
                       || (!one_limb && (i_residue_second >= r_p1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag <= '0;
        end else if (pipe_en) begin
            r_in_tag <= n_in_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_in_r0 <= i_residue_first;
            r_in_r1 <= i_residue_second;
        end
    end

    // reduce r0, r1 and the inverse modulo p1
    t_tag                 red_tag;
    logic [MB-1:0]        red_r0;
    logic [2:0][MB-1:0]   red_rem;

    rcc_mod_reduce #(
        .MB    (MB),
        .LANES (3)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_mod   (r_p1),
        .i_tag   (r_in_tag),
        .i_r0    (r_in_r0),
        .i_val   ({r_inv, r_in_r1, r_in_r0}),
        .o_tag   (red_tag),
        .o_r0    (red_r0),
        .o_rem   (red_rem)
    );

    // d = (r1 - r0) mod p1 from the reduced lanes
    t_tag          r_d_tag;
    logic [MB-1:0] r_d_r0;
    logic [MB-1:0] r_d;
    logic [MB-1:0] r_d_inv;
    logic [MB:0]   d_wrap;

    assign d_wrap = (MB+1)'(red_rem[1]) + (MB+1)'(r_p1) - (MB+1)'(red_rem[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_tag <= '0;
        end else if (pipe_en) begin
            r_d_tag <= red_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_d_r0  <= red_r0;
            r_d     <= (red_rem[1] >= red_rem[0]) ? (red_rem[1] - red_rem[0])
                                                  : d_wrap[MB-1:0];
            r_d_inv <= red_rem[2];
        end
    end

    // t = d * inv mod p1
    t_tag          mm_tag;
    logic [MB-1:0] mm_r0;
    logic [MB-1:0] mm_prod;
    logic [MB-1:0] garner_t;

    rcc_mod_mul #(
        .MB (MB)
    ) u_mod_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_mod   (r_p1),
        .i_tag   (r_d_tag),
        .i_r0    (r_d_r0),
        .i_x     (r_d),
        .i_y     (r_d_inv),
        .o_tag   (mm_tag),
        .o_r0    (mm_r0),
        .o_prod  (mm_prod)
    );

    // a zero second modulus reduces everything to zero
    assign garner_t = (r_p1 == '0) ? '0 : mm_prod;

    // z = p0 * t + r0, with tag and r0 riding alongside
    logic [P_W-1:0] z_val;
    t_tag           r_z_tag [0:MUL_LAT-1];
    logic [MB-1:0]  r_z_r0  [0:MUL_LAT-1];

    rcc_wide_mul #(
        .MB (MB)
    ) u_z_mul (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_a      (r_p0),
        .i_b      (garner_t),
        .i_addend (mm_r0),
        .o_prod   (z_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MUL_LAT; s++) begin
                r_z_tag[s] <= '0;
            end
        end else if (pipe_en) begin
            r_z_tag[0] <= mm_tag;
            for (int s = 1; s < MUL_LAT; s++) begin
                r_z_tag[s] <= r_z_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_z_r0[0] <= mm_r0;
            for (int s = 1; s < MUL_LAT; s++) begin
                r_z_r0[s] <= r_z_r0[s-1];
            end
        end
    end

    // Q = p0 * p1 follows the configuration, settles long before any word
    logic [P_W-1:0] q_val;

    rcc_wide_mul #(
        .MB (MB)
    ) u_q_mul (
        .i_clk    (i_clk),
        .i_en     (1'b1),
        .i_a      (r_p0),
        .i_b      (r_p1),
        .i_addend ('0),
        .o_prod   (q_val)
    );

    // sign decision
    t_tag           r_e_tag;
    logic           r_e_neg;
    logic [P_W-1:0] r_e_z;
    logic [MB-1:0]  r_e_r0;
    logic           n_e_neg;

    always_comb begin
        if (one_limb) begin
            n_e_neg = r_z_r0[MUL_LAT-1] > (r_p0 >> 1);
        end else begin
            n_e_neg = z_val > (q_val >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_tag <= '0;
        end else if (pipe_en) begin
            r_e_tag <= r_z_tag[MUL_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_e_neg <= n_e_neg;
            r_e_z   <= z_val;
            r_e_r0  <= r_z_r0[MUL_LAT-1];
        end
    end

    // magnitude and result word
    logic [WIDE_W-1:0] wide_mag;
    logic [LOW_W-1:0]  one_mag;
    t_result           res_word;

    assign wide_mag = r_e_neg ? (WIDE_W'(q_val) - WIDE_W'(r_e_z)) : WIDE_W'(r_e_z);
    assign one_mag  = r_e_neg ? (LOW_W'(r_p0) - LOW_W'(r_e_r0)) : LOW_W'(r_e_r0);

    always_comb begin
        res_word.neg = r_e_neg;
        res_word.bad = r_e_tag.bad;
        if (one_limb) begin
            res_word.mag_low  = one_mag;
            res_word.mag_high = '0;
        end else begin
            res_word.mag_low  = wide_mag[LOW_W-1:0];
            res_word.mag_high = wide_mag[MAG_TOP:LOW_W];
        end
    end

    rcc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pipe_en && r_e_tag.valid),
        .i_data  (res_word),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_data  (fifo_data),
        .o_valid (o_out_valid),
        .o_full  (fifo_full)
    );

    assign o_is_negative    = fifo_data.neg;
    assign o_magnitude_low  = fifo_data.mag_low;
    assign o_magnitude_high = fifo_data.mag_high;
    assign o_bad_residue    = fifo_data.bad;

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_tag.valid)
        else $error("accepted word missing from input stage");

    a_frozen_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_in_tag) && $stable(r_e_tag))
        else $error("pipeline moved while frozen");

    a_out_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_e_tag.valid && pipe_en))
        else $error("output valid without a pushed word");

endmodule

`default_nettype wire

FILE: tb/sv/tb_rns_crt_centered_reconstruct.sv
// ----------------------------------------------------------------------------
// tb_rns_crt_centered_reconstruct
// Drives residue pairs through the CRT reconstruction block under several
// prime settings and checks each centered result against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rns_crt_centered_reconstruct;
    import rcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MB        = 60;
    localparam int LATENCY   = 2 * MB + 7;
    localparam int CYCLE_MAX = 400000;

    typedef struct packed {
        logic              neg;
        logic [LOW_W-1:0]  mag_low;
        logic [HIGH_W-1:0] mag_high;
        logic              bad;
    } t_coeff;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [MB-1:0]      i_residue_first = '0;
    logic [MB-1:0]      i_residue_second = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_is_negative;
    logic [LOW_W-1:0]   o_magnitude_low;
    logic [HIGH_W-1:0]  o_magnitude_high;
    logic               o_bad_residue;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MOD_FIRST;
    logic [MB-1:0]      i_cfg_data = '0;

    // predictor copy of the register file
    logic [MB-1:0]      prime_a, prime_b, inv_ab;
    logic [LIMBS_W-1:0] limbs;

    t_coeff coeff_q[$];
    int     err_count = 0;
    int     cycles = 0;
    bit     hold_long = 1'b0;
    bit     stall_busy = 1'b0;

    rns_crt_centered_reconstruct #(.MODULUS_BITS(MB)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_coeff centered_value(logic [MB-1:0] r0, logic [MB-1:0] r1);
        t_coeff c;
        logic [127:0] z, q, mag;
        logic [63:0]  a1, d, t;
        c = '0;
        if (limbs == LIMBS_ONE) begin
            c.bad = (r0 >= prime_a);
            c.neg = (r0 > (prime_a >> 1));
            c.mag_low = c.neg ? (64'(prime_a) - 64'(r0)) : 64'(r0);
            c.mag_high = '0;
        end else begin
            c.bad = (r0 >= prime_a) || (r1 >= prime_b);
            a1 = (prime_b == 0) ? 64'd0 : 64'(r0) % 64'(prime_b);
            d = (r1 >= a1) ? 64'(r1) - a1 : 64'(r1) + 64'(prime_b) - a1;
            if (prime_b == 0)
                t = 0;
            else
                t = 64'(((128'(d) % prime_b) * (128'(inv_ab) % prime_b)) % prime_b);
            z = 128'(prime_a) * 128'(t) + 128'(r0);
            q = 128'(prime_a) * 128'(prime_b);
            c.neg = (z > (q >> 1));
            mag = c.neg ? q - z : z;
            c.mag_low = mag[63:0];
            c.mag_high = mag[118:64];
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_coeff w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (coeff_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                w = coeff_q.pop_front();
                if (o_is_negative !== w.neg)
                    report_mismatch("is_negative", o_is_negative, w.neg);
                if (o_magnitude_low !== w.mag_low)
                    report_mismatch("magnitude_low", o_magnitude_low, w.mag_low);
                if (o_magnitude_high !== w.mag_high)
                    report_mismatch("magnitude_high", o_magnitude_high, w.mag_high);
                if (o_bad_residue !== w.bad)
                    report_mismatch("bad_residue", o_bad_residue, w.bad);
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(negedge i_clk) begin
        int n;
        if (hold_long) begin
            if (!stall_busy) begin
                stall_busy = 1'b1;
                i_out_stall <= 1'b1;
                for (n = 0; n < 300; n++) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_long = 1'b0;
                stall_busy = 1'b0;
            end
        end else if (cycles[9:8] == 2'b11) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [MB-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MOD_FIRST:  prime_a = data;
            CFG_MOD_SECOND: prime_b = data;
            CFG_INV:        inv_ab  = data;
            CFG_LIMBS:      limbs   = data[LIMBS_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // the sender gaps before the word; valid stays up across back-to-back words
    task automatic send_word(logic [MB-1:0] r0, logic [MB-1:0] r1, bit gap);
        int g;
        @(negedge i_clk);
        if (gap) begin
            i_in_valid <= 1'b0;
            g = $urandom_range(1, 6);
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_residue_first <= r0;
        i_residue_second <= r1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        coeff_q.insert(coeff_q.size(), centered_value(r0, r1));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (coeff_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_primes(logic [MB-1:0] a, logic [MB-1:0] b, logic [MB-1:0] inv,
                              logic [LIMBS_W-1:0] l);
        write_reg(CFG_MOD_FIRST, a);
        write_reg(CFG_MOD_SECOND, b);
        write_reg(CFG_INV, inv);
        write_reg(CFG_LIMBS, l);
    endtask

    function automatic logic [MB-1:0] rand60();
        return MB'({$urandom(), $urandom()});
    endfunction

    task automatic random_words(int n, logic [MB-1:0] a, logic [MB-1:0] b);
        int burst;
        logic [MB-1:0] r0, r1;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            // mostly canonical residues, some out of range and raw noise
            case ($urandom_range(0, 9))
                0: begin r0 = rand60(); r1 = rand60(); end
                1: begin r0 = (a == 0) ? 0 : a - 1; r1 = (b == 0) ? 0 : b - 1; end
                2: begin r0 = a >> 1; r1 = rand60() % ((b == 0) ? 1 : b); end
                default: begin
                    r0 = rand60() % ((a == 0) ? 1 : a);
                    r1 = rand60() % ((b == 0) ? 1 : b);
                end
            endcase
            if (burst == 0) burst = $urandom_range(1, 20);
            burst--;
            send_word(r0, r1, burst == 0 && $urandom_range(0, 1));
        end
    endtask

    task automatic test_reset_config();
        send_word(0, 0, 0);
        send_word(1, 1, 0);
        send_word(2, 3, 0);
        send_word('1, '1, 0);
        drain();
    endtask

    task automatic test_directed_max();
        logic [MB-1:0] a, b;
        a = 60'hFFFFFFFFFFFFFC5;
        b = 60'hFFFFFFFFFFFFF9B;
        set_primes(a, b, 60'h123456789ABCDEF, 2'd2);
        send_word(0, 0, 0);
        send_word(a - 1, b - 1, 0);
        send_word(a >> 1, 0, 0);
        send_word((a >> 1) + 1, 5, 0);
        send_word(a, b, 0);
        send_word('1, '1, 0);
        send_word(1, 0, 0);
        drain();
        write_reg(CFG_INV, '1);
        send_word(7, 60'hAAAAAAAAAAAAAAA, 0);
        drain();
        set_primes(a, b, 5, 2'd1);
        send_word(a >> 1, '1, 0);
        send_word((a >> 1) + 1, 0, 0);
        send_word(a - 1, 0, 0);
        send_word('1, 0, 0);
        send_word(0, 0, 0);
        drain();
    endtask

    task automatic test_odd_settings();
        set_primes(97, 0, 11, 2'd0);
        send_word(50, 3, 0);
        send_word(96, 0, 0);
        drain();
        set_primes(2, 3, 2, 2'd3);
        send_word(1, 2, 0);
        send_word(0, 1, 0);
        drain();
    endtask

    task automatic test_random_full();
        logic [MB-1:0] a, b;
        a = 60'hFFFFFFFFFFFFFC5;
        b = 60'hFFFFFFFFFFFFF9B;
        set_primes(a, b, rand60(), 2'd2);
        random_words(300, a, b);
        drain();
        a = 1000003;
        b = 998244353;
        set_primes(a, b, 60'h3B9ACA07 ^ rand60(), 2'd2);
        random_words(200, a, b);
        drain();
    endtask

    task automatic test_random_one_limb();
        logic [MB-1:0] a;
        a = rand60() | 60'h1;
        set_primes(a, 60'h7, 3, LIMBS_ONE);
        random_words(150, a, 7);
        drain();
    endtask

    task automatic test_backpressure();
        logic [MB-1:0] a, b;
        a = 12289;
        b = 40961;
        set_primes(a, b, 24577, 2'd2);
        hold_long = 1'b1;
        for (int i = 0; i < 200; i++)
            send_word(rand60() % a, rand60() % b, 0);
        drain();
    endtask

    initial begin
        prime_a = 60'(MOD_RESET);
        prime_b = 60'(MOD_RESET);
        inv_ab  = 60'(INV_RESET);
        limbs   = LIMBS_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_directed_max();
        test_odd_settings();
        test_random_full();
        test_random_one_limb();
        test_backpressure();
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
